[sv/multi_axis_linear_interpolator_top_assert.svh]
// Assertion macros shared by the interpolator modules.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef MULTI_AXIS_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH
`define MULTI_AXIS_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH

// same-cycle implication
`define MALI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MALI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/mali_pkg.sv]
// Shared types, constants and width helpers for the linear interpolator.
// No dependencies.
package mali_pkg;

    localparam int AXES_DEF      = 6;
    localparam int POS_WIDTH_DEF = 32;
    localparam int MAX_AXES      = 6;
    localparam int FIELD_W       = 32;
    localparam int LEN_W         = 35;
    localparam int AXIS_W        = 3;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE, S_MSET, S_MUL, S_ACC, S_SQSET, S_SQRT, S_SQEND,
        S_DSET, S_DIV, S_WB, S_DONE
    } state_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_MSET, OP_MUL, OP_ACC, OP_SQSET, OP_SQRT, OP_SQEND,
        OP_DSET, OP_DIV, OP_WB, OP_OUT
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [AXIS_W-1:0] axis;
    } dp_cmd_t;

    typedef struct packed {
        logic              is_update;
        logic              out_free;
        logic [AXIS_W-1:0] n_used;
    } dp_status_t;

    // magnitude width of an axis difference
    function automatic int mag_bits(input int pw);
        return pw + 1;
    endfunction

    // multiplier operand B width: magnitude or travelled distance
    function automatic int mulb_bits(input int pw);
        return (pw + 1 > LEN_W) ? pw + 1 : LEN_W;
    endfunction

    // product / dividend width
    function automatic int prod_bits(input int pw);
        return mag_bits(pw) + mulb_bits(pw);
    endfunction

    // sum of squares width (up to eight terms)
    function automatic int sum_bits(input int pw);
        return 2 * mag_bits(pw) + 3;
    endfunction

    // square root steps, two radicand bits each
    function automatic int sqrt_steps(input int pw);
        return (sum_bits(pw) + 1) >> 1;
    endfunction

endpackage

[sv/multi_axis_linear_interpolator_top.sv]
// One request at a time, set by the bit-serial multiplier, root and divider; the
// next is taken in the cycle after the result loads, and a held result stalls that
// hand-over. Reset clears all positions, length 0, six axes.
module multi_axis_linear_interpolator_top #(
    parameter int AXES      = mali_pkg::AXES_DEF,
    parameter int POS_WIDTH = mali_pkg::POS_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic signed [31:0] target_0,
    input  logic signed [31:0] target_1,
    input  logic signed [31:0] target_2,
    input  logic signed [31:0] target_3,
    input  logic signed [31:0] target_4,
    input  logic signed [31:0] target_5,
    input  logic [34:0]        travelled,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_0,
    output logic signed [31:0] pos_1,
    output logic signed [31:0] pos_2,
    output logic signed [31:0] pos_3,
    output logic signed [31:0] pos_4,
    output logic signed [31:0] pos_5,
    output logic [34:0]        path_length,
    output logic               overrun
);
    import mali_pkg::*;

    dp_cmd_t                          dcmd;
    dp_status_t                       dstat;
    logic [MAX_AXES-1:0][FIELD_W-1:0] tgt;
    logic [MAX_AXES-1:0][FIELD_W-1:0] pos;

    assign tgt = {target_5, target_4, target_3, target_2, target_1, target_0};

    mali_ctrl #(
        .POS_WIDTH (POS_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (dstat),
        .cmd      (dcmd)
    );

    mali_dp #(
        .AXES      (AXES),
        .POS_WIDTH (POS_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_cmd       (cmd),
        .in_target    (tgt),
        .in_travelled (travelled),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .out_pos      (pos),
        .out_len      (path_length),
        .out_ovr      (overrun),
        .cmd          (dcmd),
        .status       (dstat)
    );

    assign pos_0 = pos[0];
    assign pos_1 = pos[1];
    assign pos_2 = pos[2];
    assign pos_3 = pos[3];
    assign pos_4 = pos[4];
    assign pos_5 = pos[5];

endmodule

[sv/mali_ctrl.sv]
// Sequencer for the interpolator: walks the axes through multiply, root
// and divide phases. Depends on mali_pkg and the assertion header.
`include "multi_axis_linear_interpolator_top_assert.svh"

module mali_ctrl #(
    parameter int POS_WIDTH = mali_pkg::POS_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mali_pkg::dp_status_t status,
    output mali_pkg::dp_cmd_t    cmd
);
    import mali_pkg::*;

    localparam int MB = mulb_bits(POS_WIDTH);
    localparam int PW = prod_bits(POS_WIDTH);
    localparam int SQ = sqrt_steps(POS_WIDTH);
    localparam int CW = $clog2(PW + 1);

    state_t            state_reg, state_next;
    logic [AXIS_W-1:0] axis_reg, axis_next;
    logic [CW-1:0]     step_reg, step_next;

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            step_reg  <= step_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.axis   = axis_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                // payload captured on the accepting edge
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    axis_next  = '0;
                    state_next = S_MSET;
                end
            end
            S_MSET:
            begin
                cmd.op     = OP_MSET;
                step_next  = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op    = OP_MUL;
                step_next = step_reg + 1'b1;
                if (step_reg == CW'(MB - 1))
                    state_next = status.is_update ? S_DSET : S_ACC;
            end
            S_ACC:
            begin
                cmd.op = OP_ACC;
                if (axis_reg == status.n_used - 1'b1)
                    state_next = S_SQSET;
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_MSET;
                end
            end
            S_SQSET:
            begin
                cmd.op     = OP_SQSET;
                step_next  = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op    = OP_SQRT;
                step_next = step_reg + 1'b1;
                if (step_reg == CW'(SQ - 1))
                    state_next = S_SQEND;
            end
            S_SQEND:
            begin
                cmd.op     = OP_SQEND;
                state_next = S_DONE;
            end
            S_DSET:
            begin
                cmd.op     = OP_DSET;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op    = OP_DIV;
                step_next = step_reg + 1'b1;
                if (step_reg == CW'(PW - 1))
                    state_next = S_WB;
            end
            S_WB:
            begin
                cmd.op = OP_WB;
                if (axis_reg == status.n_used - 1'b1)
                    state_next = S_DONE;
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_MSET;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `MALI_ASSERT_IMP(a_axis_range, (state_reg == S_MSET), (axis_reg < status.n_used), "axis beyond active count")
    `MALI_ASSERT_NXT(a_load_to_mset, (state_reg == S_IDLE && in_valid), (state_reg == S_MSET), "load not followed by setup")
    `MALI_ASSERT_IMP(a_sqrt_on_start, (state_reg == S_SQSET), (!status.is_update), "root taken on update")

endmodule

[sv/mali_dp.sv]
// Datapath: position state, serial multiplier, square root and divider,
// output register. Depends on mali_pkg and the assertion header.
`include "multi_axis_linear_interpolator_top_assert.svh"

module mali_dp #(
    parameter int AXES      = mali_pkg::AXES_DEF,
    parameter int POS_WIDTH = mali_pkg::POS_WIDTH_DEF
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 cfg_we,
    input  logic [2:0]                                           cfg_wdata,
    input  logic                                                 in_cmd,
    input  logic [mali_pkg::MAX_AXES-1:0][mali_pkg::FIELD_W-1:0] in_target,
    input  logic [mali_pkg::LEN_W-1:0]                           in_travelled,
    input  logic                                                 out_ready,
    output logic                                                 out_valid,
    output logic [mali_pkg::MAX_AXES-1:0][mali_pkg::FIELD_W-1:0] out_pos,
    output logic [mali_pkg::LEN_W-1:0]                           out_len,
    output logic                                                 out_ovr,
    input  mali_pkg::dp_cmd_t                                    cmd,
    output mali_pkg::dp_status_t                                 status
);
    import mali_pkg::*;

    localparam int MW  = mag_bits(POS_WIDTH);
    localparam int MB  = mulb_bits(POS_WIDTH);
    localparam int PW  = prod_bits(POS_WIDTH);
    localparam int SW  = sum_bits(POS_WIDTH);
    localparam int SQ  = sqrt_steps(POS_WIDTH);
    localparam int AIW = $clog2(AXES);
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // architectural state
    logic signed [POS_WIDTH-1:0] start_reg [AXES];
    logic signed [POS_WIDTH-1:0] goal_reg  [AXES];
    logic signed [POS_WIDTH-1:0] cur_reg   [AXES];
    logic [LEN_W-1:0]            len_reg;
    logic [2:0]                  axes_reg;

    // request working registers
    logic               mode_reg;
    logic [LEN_W-1:0]   trav_reg;
    logic               ovr_reg;
    logic               neg_reg;
    logic [MW-1:0]      mula_reg;
    logic [MB-1:0]      mulb_reg;
    logic [PW-1:0]      acc_reg;
    logic [SW-1:0]      sum_reg;
    logic [2*SQ-1:0]    rad_reg;
    logic [SQ+1:0]      srem_reg;
    logic [SQ-1:0]      root_reg;
    logic [PW-1:0]      num_reg;
    logic [LEN_W-1:0]   drem_reg;
    logic [MW-1:0]      quo_reg;

    // output register
    logic                             oval_reg;
    logic [MAX_AXES-1:0][FIELD_W-1:0] opos_reg;
    logic [LEN_W-1:0]                 olen_reg;
    logic                             oovr_reg;

    logic [2:0]             n_used;
    logic [AIW-1:0]         ax;
    logic signed [MW-1:0]   diff;
    logic [MW-1:0]          mag;
    logic [SQ+3:0]          srem_sh;
    logic [SQ+3:0]          strial;
    logic [LEN_W:0]         drem_sh;
    logic [SQ+LEN_W-1:0]    root_ext;
    logic [POS_WIDTH-1:0]   qn;
    logic                   len_zero;

    // clamp the axis count
    always_comb
    begin
        if (axes_reg < 3'd2)
            n_used = 3'd2;
        else if (axes_reg > 3'(AXES))
            n_used = 3'(AXES);
        else
            n_used = axes_reg;
    end

    assign ax       = cmd.axis[AIW-1:0];
    assign diff     = MW'(goal_reg[ax]) - MW'(start_reg[ax]);
    assign mag      = diff[MW-1] ? MW'(-diff) : MW'(diff);
    assign srem_sh  = {srem_reg, rad_reg[2*SQ-1 -: 2]};
    assign strial   = {2'b00, root_reg, 2'b01};
    assign drem_sh  = {drem_reg, num_reg[PW-1]};
    assign root_ext = (SQ + LEN_W)'(root_reg);
    assign len_zero = (len_reg == '0);
    assign qn       = len_zero ? '0 : POS_WIDTH'(quo_reg);

    assign status.is_update = mode_reg;
    assign status.out_free  = !oval_reg || out_ready;
    assign status.n_used    = n_used;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            axes_reg <= 3'd6;
        else if (cfg_we)
            axes_reg <= cfg_wdata;
    end

    // positions and path length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                start_reg[i] <= '0;
                goal_reg[i]  <= '0;
                cur_reg[i]   <= '0;
            end
            len_reg <= '0;
        end
        else
        begin
            if (cmd.op == OP_LOAD && !in_cmd)
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    start_reg[i] <= cur_reg[i];
                    if (3'(i) < n_used)
                        goal_reg[i] <= POS_WIDTH'($signed(in_target[i]));
                    else
                        goal_reg[i] <= cur_reg[i];
                end
            end
            if (cmd.op == OP_SQEND)
                len_reg <= (root_ext > (SQ + LEN_W)'(LEN_MAX)) ? LEN_MAX
                                                               : LEN_W'(root_reg);
            if (cmd.op == OP_WB)
                cur_reg[ax] <= neg_reg ? start_reg[ax] - $signed(qn)
                                       : start_reg[ax] + $signed(qn);
        end
    end

    // control flags of the request in progress
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            ovr_reg  <= 1'b0;
            oval_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_LOAD)
            begin
                mode_reg <= in_cmd;
                ovr_reg  <= in_cmd && (in_travelled > len_reg);
            end
            if (cmd.op == OP_OUT)
                oval_reg <= 1'b1;
            else if (out_ready)
                oval_reg <= 1'b0;
        end
    end

    // arithmetic units
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                trav_reg <= (in_travelled > len_reg) ? len_reg : in_travelled;
                sum_reg  <= '0;
            end
            OP_MSET:
            begin
                neg_reg  <= diff[MW-1];
                mula_reg <= mag;
                mulb_reg <= mode_reg ? MB'(trav_reg) : MB'(mag);
                acc_reg  <= '0;
            end
            OP_MUL:
            begin
                acc_reg  <= (acc_reg << 1) + (mulb_reg[MB-1] ? PW'(mula_reg) : '0);
                mulb_reg <= mulb_reg << 1;
            end
            OP_ACC:
            begin
                sum_reg <= sum_reg + SW'(acc_reg);
            end
            OP_SQSET:
            begin
                rad_reg  <= (2*SQ)'(sum_reg);
                srem_reg <= '0;
                root_reg <= '0;
            end
            OP_SQRT:
            begin
                rad_reg <= rad_reg << 2;
                if (srem_sh >= strial)
                begin
                    srem_reg <= (SQ+2)'(srem_sh - strial);
                    root_reg <= {root_reg[SQ-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= (SQ+2)'(srem_sh);
                    root_reg <= {root_reg[SQ-2:0], 1'b0};
                end
            end
            OP_DSET:
            begin
                num_reg  <= acc_reg;
                drem_reg <= '0;
                quo_reg  <= '0;
            end
            OP_DIV:
            begin
                num_reg <= num_reg << 1;
                if (drem_sh >= {1'b0, len_reg})
                begin
                    drem_reg <= LEN_W'(drem_sh - {1'b0, len_reg});
                    quo_reg  <= {quo_reg[MW-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= LEN_W'(drem_sh);
                    quo_reg  <= {quo_reg[MW-2:0], 1'b0};
                end
            end
            OP_OUT:
            begin
                for (int i = 0; i < MAX_AXES; i++)
                begin
                    if (i < AXES)
                        opos_reg[i] <= FIELD_W'(cur_reg[i]);
                    else
                        opos_reg[i] <= '0;
                end
                olen_reg <= len_reg;
                oovr_reg <= ovr_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = oval_reg;
    assign out_pos   = opos_reg;
    assign out_len   = olen_reg;
    assign out_ovr   = oovr_reg;

    `MALI_ASSERT_IMP(a_ovr_update, ovr_reg, mode_reg, "overrun flagged on a start request")
    `MALI_ASSERT_IMP(a_trav_clamped, (cmd.op == OP_WB), (trav_reg <= len_reg), "travelled not clamped")
    `MALI_ASSERT_NXT(a_out_loaded, (cmd.op == OP_OUT), oval_reg, "result not presented")

endmodule

[tb/sv/multi_axis_linear_interpolator_top_tb.sv]
// Testbench for the six-axis straight-line interpolator: directed corner cases,
// then random move sequences checked against a scoreboard. Needs mali_pkg and the RTL.
`timescale 1ns / 1ps

module multi_axis_linear_interpolator_top_tb;

    localparam int  N_AX       = 6;
    localparam bit  CMD_START  = 1'b0;
    localparam bit  CMD_UPDATE = 1'b1;
    localparam longint CYCLE_LIMIT = 6000000;
    localparam logic [34:0] LEN_ONES = '1;

    typedef struct {
        bit                 cmd;
        logic signed [31:0] target [N_AX];
        logic [34:0]        travelled;
    } request_t;

    typedef struct {
        logic signed [31:0] pos [N_AX];
        logic [34:0]        path_length;
        bit                 overrun;
    } position_t;

    // Scoreboard: interpolator state copy and queue of expected positions
    class interp_scoreboard;
        logic signed [31:0] start_pt [N_AX];
        logic signed [31:0] goal_pt  [N_AX];
        logic signed [31:0] cur_pt   [N_AX];
        logic [34:0]        move_len;
        logic [2:0]         axes_reg;
        position_t          pending_q [$];
        int                 mismatches;
        int                 results_seen;

        function new();
            for (int i = 0; i < N_AX; i++)
            begin
                start_pt[i] = 0;
                goal_pt[i]  = 0;
                cur_pt[i]   = 0;
            end
            move_len     = 0;
            axes_reg     = 3'd6;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_axes(logic [2:0] v);
            axes_reg = v;
        endfunction

        function int used_axes();
            if (axes_reg < 2)
                return 2;
            if (axes_reg > N_AX)
                return N_AX;
            return axes_reg;
        endfunction

        // integer square root, floor
        function logic [63:0] root_of(logic [127:0] v);
            logic [127:0] r;
            logic [127:0] c;
            r = 0;
            for (int b = 55; b >= 0; b--)
            begin
                c = r | (128'd1 << b);
                if (c * c <= v)
                    r = c;
            end
            return r[63:0];
        endfunction

        function void note_request(request_t rq);
            int           n;
            bit           ovr;
            longint       d;
            logic [63:0]  m;
            logic [127:0] sum;
            logic [127:0] prod;
            logic [63:0]  q;
            logic [63:0]  p;
            logic [63:0]  len;
            logic [34:0]  t;
            position_t    e;
            n   = used_axes();
            ovr = 0;
            if (rq.cmd == CMD_START)
            begin
                sum = 0;
                for (int i = 0; i < N_AX; i++)
                begin
                    start_pt[i] = cur_pt[i];
                    if (i < n)
                    begin
                        goal_pt[i] = rq.target[i];
                        d = longint'(goal_pt[i]) - longint'(start_pt[i]);
                        m = (d < 0) ? -d : d;
                        sum = sum + 128'(m) * 128'(m);
                    end
                    else
                        goal_pt[i] = cur_pt[i];
                end
                len = root_of(sum);
                move_len = (len > 64'(LEN_ONES)) ? LEN_ONES : len[34:0];
            end
            else
            begin
                t = rq.travelled;
                if (t > move_len)
                begin
                    t   = move_len;
                    ovr = 1;
                end
                for (int i = 0; i < n; i++)
                begin
                    d = longint'(goal_pt[i]) - longint'(start_pt[i]);
                    m = (d < 0) ? -d : d;
                    q = 0;
                    if (move_len != 0)
                    begin
                        prod = 128'(m) * 128'(t);
                        prod = prod / 128'(move_len);
                        q = prod[63:0];
                    end
                    p = (d < 0) ? 64'(longint'(start_pt[i])) - q
                                : 64'(longint'(start_pt[i])) + q;
                    cur_pt[i] = p[31:0];
                end
            end
            for (int i = 0; i < N_AX; i++)
                e.pos[i] = cur_pt[i];
            e.path_length = move_len;
            e.overrun     = ovr;
            pending_q.push_back(e);
        endfunction

        function void note_fail(string what, longint exp_v, longint act_v);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at result %0d: %s expected %0d got %0d",
                         results_seen, what, exp_v, act_v);
        endfunction

        function void check_result(position_t a);
            position_t e;
            results_seen++;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d, nothing pending", results_seen);
                return;
            end
            e = pending_q.pop_front();
            for (int i = 0; i < N_AX; i++)
                if (a.pos[i] !== e.pos[i])
                    note_fail($sformatf("pos_%0d", i), e.pos[i], a.pos[i]);
            if (a.path_length !== e.path_length)
                note_fail("path_length", e.path_length, a.path_length);
            if (a.overrun !== e.overrun)
                note_fail("overrun", e.overrun, a.overrun);
        endfunction
    endclass

    logic               clk = 0;
    logic               rst_n = 0;
    logic               cfg_we = 0;
    logic [2:0]         cfg_wdata = 0;
    logic               in_valid = 0;
    logic               in_ready;
    logic               cmd = 0;
    logic signed [31:0] tgt [N_AX] = '{default: 0};
    logic [34:0]        travelled = 0;
    logic               out_valid;
    logic               out_ready = 0;
    logic signed [31:0] pos [N_AX];
    logic [34:0]        path_length;
    logic               overrun;

    logic   idle_en = 0;
    logic   hold_go = 0;
    logic   hold_off = 0;
    longint cycles = 0;
    int     n_requests = 0;

    interp_scoreboard sb = new();

    multi_axis_linear_interpolator_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
        .target_0(tgt[0]), .target_1(tgt[1]), .target_2(tgt[2]),
        .target_3(tgt[3]), .target_4(tgt[4]), .target_5(tgt[5]),
        .travelled(travelled), .out_valid(out_valid), .out_ready(out_ready),
        .pos_0(pos[0]), .pos_1(pos[1]), .pos_2(pos[2]),
        .pos_3(pos[3]), .pos_4(pos[4]), .pos_5(pos[5]),
        .path_length(path_length), .overrun(overrun)
    );

    always #5 clk = ~clk;

    // cycle count and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[multi_axis_linear_interpolator_top] ERROR");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off
    always @(posedge clk)
    begin
        if (hold_off)
            out_ready <= 1'b0;
        else if (idle_en)
            out_ready <= ($urandom_range(0, 99) >= 13);
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (5000) @(posedge clk);
        hold_off <= 1'b0;
    end

    // result monitor
    always @(posedge clk)
    begin
        position_t a;
        if (rst_n && out_valid && out_ready)
        begin
            for (int i = 0; i < N_AX; i++)
                a.pos[i] = pos[i];
            a.path_length = path_length;
            a.overrun     = overrun;
            sb.check_result(a);
        end
    end

    // offer one request and hold it until accepted
    task automatic send_request(request_t rq);
        while (idle_en && $urandom_range(0, 99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= rq.cmd;
        travelled <= rq.travelled;
        for (int i = 0; i < N_AX; i++)
            tgt[i] <= rq.target[i];
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(rq);
        n_requests++;
    endtask

    task automatic send_start(logic signed [31:0] t0, logic signed [31:0] t1,
                              logic signed [31:0] t2, logic signed [31:0] t3,
                              logic signed [31:0] t4, logic signed [31:0] t5);
        request_t rq;
        rq.cmd = CMD_START;
        rq.target = '{t0, t1, t2, t3, t4, t5};
        rq.travelled = {3'($urandom_range(0, 7)), $urandom()};
        send_request(rq);
    endtask

    task automatic send_update(logic [34:0] trav_dist);
        request_t rq;
        rq.cmd = CMD_UPDATE;
        for (int i = 0; i < N_AX; i++)
            rq.target[i] = $urandom();
        rq.travelled = trav_dist;
        send_request(rq);
    endtask

    // drain, let the block settle, then write the axis count
    task automatic write_axes(logic [2:0] v);
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (800) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_axes(v);
    endtask

    function automatic logic signed [31:0] rand_target();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return $signed($urandom_range(0, 20000)) - 10000;
        if (sel < 9)
            return $urandom();
        return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
    endfunction

    function automatic logic [34:0] rand_travel();
        logic [63:0] r;
        int          sel;
        r   = {$urandom(), $urandom()};
        sel = $urandom_range(0, 9);
        if (sel < 8)
            return 35'(r % (64'(sb.move_len) + 1));
        if (sel < 9)
            return sb.move_len + 35'($urandom_range(1, 1000));
        return r[34:0];
    endfunction

    task automatic random_phase(int count);
        int sent;
        int ups;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: a lone update or a lone start
                if ($urandom_range(0, 1) != 0)
                    send_update(rand_travel());
                else
                    send_start(rand_target(), rand_target(), rand_target(),
                               rand_target(), rand_target(), rand_target());
                sent++;
            end
            else
            begin
                send_start(rand_target(), rand_target(), rand_target(),
                           rand_target(), rand_target(), rand_target());
                sent++;
                ups = $urandom_range(1, 8);
                for (int k = 0; k < ups; k++)
                begin
                    send_update(rand_travel());
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        logic [2:0] axes_plan [9];
        axes_plan = '{3'd2, 3'd6, 3'd3, 3'd0, 3'd5, 3'd7, 3'd4, 3'd1, 3'd2};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_axes(3'd6);

        // directed: zero-length move, extremes of targets and travelled distance
        send_start(0, 0, 0, 0, 0, 0);
        send_update(35'd0);
        send_update(35'd5);
        send_start(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                   32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_update(sb.move_len >> 1);
        send_update(sb.move_len);
        send_update(LEN_ONES);
        send_start(32'sh80000000, 32'sh80000000, 32'sh80000000,
                   32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_update(35'd1);
        send_update(sb.move_len - 1);
        send_update(sb.move_len + 1);
        send_start(32'sh7fffffff, 32'sh80000000, -1, 1, 32'sh55555555, 32'shaaaaaaaa);
        send_update(sb.move_len / 3);
        send_update(LEN_ONES);
        send_start(-3, 4, 0, 0, 0, 0);
        send_update(35'd2);
        send_update(35'd5);

        // inactive axes keep position while targets are ignored
        write_axes(3'd2);
        send_start(100, -200, 32'sh7fffffff, 32'sh80000000, 7, -7);
        send_update(sb.move_len >> 1);
        send_start(100, -200, 5, 5, 5, 5);
        send_update(35'd3);

        idle_en <= 1'b1;
        for (int ph = 0; ph < 9; ph++)
        begin
            write_axes(axes_plan[ph]);
            if (ph == 4)
                idle_en <= 1'b0;
            if (ph == 5)
                idle_en <= 1'b1;
            if (ph == 2)
                hold_go <= 1'b1;
            random_phase(152);
        end

        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (800) @(posedge clk);

        $display("covered %0d requests and %0d results over axis counts 0..7,",
                 n_requests, sb.results_seen);
        $display("with zero-length moves, overruns, full-range targets and stalls");
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("[multi_axis_linear_interpolator_top] OK");
        else
            $display("[multi_axis_linear_interpolator_top] ERROR");
        $finish;
    end

endmodule
